// File: rtl/timing_path_stats_monitor_assert.svh
// Assertion macros used by the tpsm_table module of the timing path statistics monitor.
// Depends on nothing; each user supplies clock and reset names.
`ifndef TIMING_PATH_STATS_MONITOR_ASSERT_SVH
`define TIMING_PATH_STATS_MONITOR_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define TPSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define TPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/tpsm_pkg.sv
// Package for the timing path statistics monitor: payload types, sizes, states.
// Used by every module of the block but tpsm_ram.
`timescale 1ns / 1ps
package tpsm_pkg;
    localparam int TableEntries = 64;
    localparam int IdxW = $clog2(TableEntries);
    localparam int Window = 3;
    localparam int WinPosW = (Window > 1) ? $clog2(Window) : 1;
    localparam int EntryW = 8 + 8 + 4 * 32;
    localparam int QDepth = 2;

    typedef enum logic {
        ACT_RECORD = 1'b0,
        ACT_READ   = 1'b1
    } t_action;

    typedef struct packed {
        logic        action;
        logic [5:0]  entry_index;
        logic [7:0]  job_src;
        logic [7:0]  job_dst;
        logic [31:0] arr_time;
        logic [31:0] rel_time;
        logic [31:0] exe_time;
        logic [31:0] jitter_time;
        logic [31:0] abort_time;
    } t_in_item;

    typedef struct packed {
        logic        deadline_missed;
        logic [1:0]  misses_in_window;
        logic [1:0]  worst_misses;
        logic        dropped;
        logic        entry_valid;
        logic [7:0]  entry_src;
        logic [7:0]  entry_dst;
        logic [31:0] entry_best;
        logic [31:0] entry_worst;
        logic [31:0] entry_max_jitter;
        logic [31:0] entry_max_abort;
    } t_out_item;

    // Work item handed from the front part to the table engine.
    typedef struct packed {
        logic        is_read;
        logic [5:0]  entry_index;
        logic [7:0]  job_src;
        logic [7:0]  job_dst;
        logic [31:0] exe_time;
        logic [31:0] jitter_time;
        logic [31:0] abort_time;
        logic        deadline_missed;
        logic [1:0]  misses_in_window;
        logic [1:0]  worst_misses;
    } t_job;

    typedef struct packed {
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [31:0] best;
        logic [31:0] worst;
        logic [31:0] jitter;
        logic [31:0] abort_t;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_UPDATE,
        ST_READ,
        ST_OUT
    } t_state;
endpackage

// File: rtl/tpsm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tpsm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/tpsm_front.sv
// Front part: takes input beats, computes the deadline flag, keeps the miss ring.
// Depends on tpsm_pkg.
`timescale 1ns / 1ps
module tpsm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  tpsm_pkg::t_in_item i_item,
    input  logic [31:0]        i_deadline,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output tpsm_pkg::t_job     o_job
);
    import tpsm_pkg::*;

    logic [Window-1:0]  r_ring, n_ring;
    logic [WinPosW-1:0] r_pos, n_pos;
    logic [1:0]         r_worst, n_worst;
    logic               miss, accept;
    logic [32:0]        lhs, rhs;
    logic [1:0]         cnt_now, cnt_new;

    function automatic logic [1:0] sat_count(input logic [Window-1:0] ring);
        logic [5:0] n;
        n = '0;
        for (int j = 0; j < Window; j++) begin
            n = n + 6'(ring[j]);
        end
        return (n > 6'd3) ? 2'd3 : n[1:0];
    endfunction

    assign o_ready = i_job_ready;
    assign accept  = i_valid && i_job_ready;
    assign lhs     = {1'b0, i_item.rel_time} + {1'b0, i_item.exe_time};
    assign rhs     = {1'b0, i_item.arr_time} + {1'b0, i_deadline};
    assign miss    = lhs > rhs;

    always_comb begin
        n_ring = r_ring;
        n_ring[r_pos] = miss;
        cnt_now = sat_count(r_ring);
        cnt_new = sat_count(n_ring);
        n_pos = (r_pos == WinPosW'(Window - 1)) ? '0 : r_pos + 1'b1;
        n_worst = (cnt_new > r_worst) ? cnt_new : r_worst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring  <= '0;
            r_pos   <= '0;
            r_worst <= '0;
        end else if (accept && i_item.action == ACT_RECORD) begin
            r_ring  <= n_ring;
            r_pos   <= n_pos;
            r_worst <= n_worst;
        end
    end

    always_comb begin
        o_job_valid            = i_valid;
        o_job.is_read          = (i_item.action == ACT_READ);
        o_job.entry_index      = i_item.entry_index;
        o_job.job_src          = i_item.job_src;
        o_job.job_dst          = i_item.job_dst;
        o_job.exe_time         = i_item.exe_time;
        o_job.jitter_time      = i_item.jitter_time;
        o_job.abort_time       = i_item.abort_time;
        o_job.deadline_missed  = o_job.is_read ? 1'b0 : miss;
        o_job.misses_in_window = o_job.is_read ? cnt_now : cnt_new;
        o_job.worst_misses     = o_job.is_read ? r_worst : n_worst;
    end
endmodule

// File: rtl/tpsm_queue.sv
// Short queue of classified jobs between the front part and the table engine.
// Depends on tpsm_pkg.
`timescale 1ns / 1ps
module tpsm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tpsm_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output tpsm_pkg::t_job o_job
);
    import tpsm_pkg::*;

    t_job       r_slot [QDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'(QDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_slot[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: rtl/tpsm_table.sv
// Back part: table engine that scans the pair table in RAM, updates or inserts
// entries and builds the result beat. Depends on tpsm_pkg, tpsm_ram and the macros.
`timescale 1ns / 1ps
`include "timing_path_stats_monitor_assert.svh"
module tpsm_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tpsm_pkg::t_job      i_job,
    output logic                o_valid,
    input  logic                i_ready,
    output tpsm_pkg::t_out_item o_item
);
    import tpsm_pkg::*;

    t_state                r_state, n_state;
    t_job                  r_job, n_job;
    logic [TableEntries-1:0] r_vld, n_vld;
    logic [IdxW-1:0]       r_idx, n_idx;
    logic                  r_free_ok, n_free_ok;
    logic [IdxW-1:0]       r_free, n_free;
    logic                  r_hit, n_hit;
    t_out_item             r_out, n_out;
    logic                  r_ovalid, n_ovalid;

    logic            we;
    logic [IdxW-1:0] waddr, raddr;
    t_entry          wdata, rdata;

    tpsm_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vld    <= n_vld;
            r_ovalid <= n_ovalid;
        end
        r_job     <= n_job;
        r_idx     <= n_idx;
        r_free_ok <= n_free_ok;
        r_free    <= n_free;
        r_hit     <= n_hit;
        r_out     <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_vld     = r_vld;
        n_idx     = r_idx;
        n_free_ok = r_free_ok;
        n_free    = r_free;
        n_hit     = r_hit;
        n_out     = r_out;
        n_ovalid  = r_ovalid;
        o_ready   = 1'b0;
        we        = 1'b0;
        waddr     = r_idx;
        wdata     = rdata;
        raddr     = r_idx;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_job     = i_job;
                    n_free_ok = 1'b0;
                    n_hit     = 1'b0;
                    if (i_job.is_read) begin
                        n_idx   = i_job.entry_index;
                        n_state = ST_READ;
                    end else begin
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            // Read one table entry; its registered read data is checked in the next state, ST_CHECK.
            ST_SCAN: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_vld[r_idx] && rdata.src == r_job.job_src
                        && rdata.dst == r_job.job_dst) begin
                    n_hit   = 1'b1;
                    n_state = ST_UPDATE;
                end else begin
                    if (!r_vld[r_idx] && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_idx;
                    end
                    if (r_idx == IdxW'(TableEntries - 1)) begin
                        n_state = ST_UPDATE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_UPDATE: begin
                if (!r_ovalid || i_ready) begin
                    n_out.deadline_missed  = r_job.deadline_missed;
                    n_out.misses_in_window = r_job.misses_in_window;
                    n_out.worst_misses     = r_job.worst_misses;
                    n_out.dropped          = !(r_hit || r_free_ok);
                    if (r_hit) begin
                        wdata.src     = rdata.src;
                        wdata.dst     = rdata.dst;
                        wdata.best    = (rdata.best > r_job.exe_time)
                                        ? r_job.exe_time : rdata.best;
                        wdata.worst   = (rdata.worst < r_job.exe_time)
                                        ? r_job.exe_time : rdata.worst;
                        wdata.jitter  = (rdata.jitter < r_job.jitter_time)
                                        ? r_job.jitter_time : rdata.jitter;
                        wdata.abort_t = (rdata.abort_t < r_job.abort_time)
                                        ? r_job.abort_time : rdata.abort_t;
                        waddr         = r_idx;
                    end else begin
                        wdata.src     = r_job.job_src;
                        wdata.dst     = r_job.job_dst;
                        wdata.best    = r_job.exe_time;
                        wdata.worst   = r_job.exe_time;
                        wdata.jitter  = r_job.jitter_time;
                        wdata.abort_t = r_job.abort_time;
                        waddr         = r_free;
                    end
                    we = r_hit || r_free_ok;
                    if (we) begin
                        n_vld[waddr] = 1'b1;
                    end
                    n_out.entry_valid      = we;
                    n_out.entry_src        = we ? wdata.src : '0;
                    n_out.entry_dst        = we ? wdata.dst : '0;
                    n_out.entry_best       = we ? wdata.best : '0;
                    n_out.entry_worst      = we ? wdata.worst : '0;
                    n_out.entry_max_jitter = we ? wdata.jitter : '0;
                    n_out.entry_max_abort  = we ? wdata.abort_t : '0;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_out.deadline_missed  = 1'b0;
                    n_out.misses_in_window = r_job.misses_in_window;
                    n_out.worst_misses     = r_job.worst_misses;
                    n_out.dropped          = 1'b0;
                    n_out.entry_valid      = r_vld[r_idx];
                    n_out.entry_src        = n_out.entry_valid ? rdata.src : '0;
                    n_out.entry_dst        = n_out.entry_valid ? rdata.dst : '0;
                    n_out.entry_best       = n_out.entry_valid ? rdata.best : '0;
                    n_out.entry_worst      = n_out.entry_valid ? rdata.worst : '0;
                    n_out.entry_max_jitter = n_out.entry_valid ? rdata.jitter : '0;
                    n_out.entry_max_abort  = n_out.entry_valid ? rdata.abort_t : '0;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `TPSM_ASSERT_NEXT(a_write_sets_valid, i_clk, i_rst_n, we, r_vld[$past(waddr)])
    `TPSM_ASSERT_IMP(a_drop_no_entry, i_clk, i_rst_n, r_ovalid && r_out.dropped, !r_out.entry_valid)
    `TPSM_ASSERT_IMP(a_read_no_write, i_clk, i_rst_n, r_state == ST_OUT, !we)
endmodule

// File: rtl/timing_path_stats_monitor.sv
// Top level of the timing path statistics monitor.
// Depends on tpsm_pkg, tpsm_front, tpsm_queue and tpsm_table.
`timescale 1ns / 1ps
// A record beat is classified on entry (deadline check, miss ring) and then
// searched against the 64-entry pair table entry by entry, through the
// registered read of the table RAM; a read beat reads its one entry directly.
// A two-deep queue lets new beats enter while the engine works. Table valid
// marks all clear at reset.
module timing_path_stats_monitor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tpsm_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output tpsm_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_data
);
    import tpsm_pkg::*;

    logic [31:0] r_deadline;
    logic        f_valid, f_ready, b_valid, b_ready;
    t_job        f_job, b_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
        end else if (i_cfg_we) begin
            r_deadline <= i_cfg_data;
        end
    end

    tpsm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .i_deadline(r_deadline),
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job)
    );

    tpsm_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .o_ready(f_ready),
        .i_job(f_job), .o_valid(b_valid), .i_ready(b_ready), .o_job(b_job)
    );

    tpsm_table u_table (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(b_valid), .o_ready(b_ready),
        .i_job(b_job), .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );
endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the timing path statistics monitor.
// Depends on tpsm_pkg and the timing_path_stats_monitor RTL; predicts each result beat itself.
`timescale 1ns / 1ps
module tb_top;
    import tpsm_pkg::*;

    localparam int NumRandom  = 830;
    localparam int StallLimit = 6000;
    localparam int DrainWait  = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;
    logic      i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;

    timing_path_stats_monitor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the block's state.
    logic [31:0] pm_deadline;
    logic        pm_valid [TableEntries];
    logic [7:0]  pm_src   [TableEntries];
    logic [7:0]  pm_dst   [TableEntries];
    logic [31:0] pm_best  [TableEntries];
    logic [31:0] pm_worst [TableEntries];
    logic [31:0] pm_jit   [TableEntries];
    logic [31:0] pm_abt   [TableEntries];
    logic        pm_ring  [Window];
    int          pm_pos;
    logic [1:0]  pm_worst_cnt;

    t_out_item expected_beats[$];
    int n_in, n_out, n_err, n_drop, n_miss, n_read, idle_cycles, hold_left;

    function automatic logic [1:0] ring_count();
        int n;
        n = 0;
        for (int j = 0; j < Window; j++) n += int'(pm_ring[j]);
        return (n > 3) ? 2'd3 : 2'(n);
    endfunction

    function automatic void fill_entry(ref t_out_item r, input int k);
        r.entry_valid      = 1'b1;
        r.entry_src        = pm_src[k];
        r.entry_dst        = pm_dst[k];
        r.entry_best       = pm_best[k];
        r.entry_worst      = pm_worst[k];
        r.entry_max_jitter = pm_jit[k];
        r.entry_max_abort  = pm_abt[k];
    endfunction

    function automatic t_out_item predict_stats(t_in_item it);
        t_out_item r;
        int hit;
        r = '0;
        hit = -1;
        if (t_action'(it.action) == ACT_READ) begin
            r.misses_in_window = ring_count();
            r.worst_misses     = pm_worst_cnt;
            if (pm_valid[it.entry_index]) fill_entry(r, int'(it.entry_index));
            return r;
        end
        // Both sums are 33 bits wide so neither side wraps.
        r.deadline_missed = ({1'b0, it.rel_time} + {1'b0, it.exe_time}) >
                            ({1'b0, it.arr_time} + {1'b0, pm_deadline});
        pm_ring[pm_pos] = r.deadline_missed;
        pm_pos = (pm_pos + 1) % Window;
        r.misses_in_window = ring_count();
        if (r.misses_in_window > pm_worst_cnt) pm_worst_cnt = r.misses_in_window;
        r.worst_misses = pm_worst_cnt;
        for (int k = 0; k < TableEntries; k++) begin
            if (hit < 0 && pm_valid[k] && pm_src[k] == it.job_src && pm_dst[k] == it.job_dst)
                hit = k;
        end
        if (hit >= 0) begin
            if (pm_best[hit] > it.exe_time) pm_best[hit] = it.exe_time;
            if (pm_worst[hit] < it.exe_time) pm_worst[hit] = it.exe_time;
            if (pm_jit[hit] < it.jitter_time) pm_jit[hit] = it.jitter_time;
            if (pm_abt[hit] < it.abort_time) pm_abt[hit] = it.abort_time;
        end else begin
            for (int k = 0; k < TableEntries; k++) begin
                if (hit < 0 && !pm_valid[k]) begin
                    hit = k;
                    pm_valid[k] = 1'b1;
                    pm_src[k]   = it.job_src;
                    pm_dst[k]   = it.job_dst;
                    pm_best[k]  = it.exe_time;
                    pm_worst[k] = it.exe_time;
                    pm_jit[k]   = it.jitter_time;
                    pm_abt[k]   = it.abort_time;
                end
            end
        end
        if (hit >= 0) fill_entry(r, hit);
        else r.dropped = 1'b1;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            n_err++;
            $display("%0t mismatch %s: expected %0h, actual %0h", $realtime, name, want, got);
        end
    endtask

    // Receiver: checks each result beat and decides ready for the next edge.
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_valid && i_ready) begin
            n_out++;
            if (expected_beats.size() == 0) begin
                n_err++;
                $display("%0t mismatch: expected no beat, actual %0h", $realtime, o_item);
            end else begin
                e = expected_beats.pop_front();
                check_field("deadline_missed", 32'(e.deadline_missed),
                            32'(o_item.deadline_missed));
                check_field("misses_in_window", 32'(e.misses_in_window),
                            32'(o_item.misses_in_window));
                check_field("worst_misses", 32'(e.worst_misses), 32'(o_item.worst_misses));
                check_field("dropped", 32'(e.dropped), 32'(o_item.dropped));
                check_field("entry_valid", 32'(e.entry_valid), 32'(o_item.entry_valid));
                check_field("entry_src", 32'(e.entry_src), 32'(o_item.entry_src));
                check_field("entry_dst", 32'(e.entry_dst), 32'(o_item.entry_dst));
                check_field("entry_best", e.entry_best, o_item.entry_best);
                check_field("entry_worst", e.entry_worst, o_item.entry_worst);
                check_field("entry_max_jitter", e.entry_max_jitter, o_item.entry_max_jitter);
                check_field("entry_max_abort", e.entry_max_abort, o_item.entry_max_abort);
                n_drop += int'(e.dropped);
                n_miss += int'(e.deadline_missed);
            end
            // A long hold-off once, so the input queue fills and stalls.
            if (n_out == 120) hold_left = 900;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (n_out >= 500 && n_out < 650) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 16);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(t_in_item it);
        if (!(n_in >= 300 && n_in < 450)) begin
            while ($urandom_range(0, 99) < 16) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_beats.push_back(predict_stats(it));
        n_in++;
        if (t_action'(it.action) == ACT_READ) n_read++;
    endtask

    // Waits for the block to drain, then writes the deadline register.
    task automatic set_deadline(logic [31:0] v);
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pm_deadline = v;
        @(posedge i_clk);
    endtask

    function automatic t_in_item rec(logic [7:0] s, logic [7:0] d, logic [31:0] arr,
                                     logic [31:0] rel, logic [31:0] exe,
                                     logic [31:0] jit, logic [31:0] abt);
        t_in_item it;
        it = '0;
        it.action = ACT_RECORD;
        it.entry_index = 6'($urandom);
        it.job_src = s; it.job_dst = d;
        it.arr_time = arr; it.rel_time = rel; it.exe_time = exe;
        it.jitter_time = jit; it.abort_time = abt;
        return it;
    endfunction

    function automatic t_in_item rd(logic [5:0] k);
        t_in_item it;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.action = ACT_READ;
        it.entry_index = k;
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        logic [31:0] arr;
        if ($urandom_range(0, 99) < 20) return rd(6'($urandom));
        arr = $urandom;
        if ($urandom_range(0, 99) < 70) begin
            // Small pair pool and times near the deadline, so pairs repeat and
            // the miss flag toggles.
            it = rec(8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)), arr,
                     arr + $urandom_range(0, 60), $urandom_range(0, 60),
                     $urandom_range(0, 1000), $urandom_range(0, 1000));
        end else begin
            it = rec(8'($urandom), 8'($urandom), arr, $urandom, $urandom,
                     $urandom, $urandom);
        end
        return it;
    endfunction

    typedef struct {
        t_in_item  stim;
        bit        known;
        t_out_item result;
    } t_row;

    initial begin
        t_row rows[$];
        t_out_item e;
        n_in = 0; n_out = 0; n_err = 0; n_drop = 0; n_miss = 0; n_read = 0;
        idle_cycles = 0; hold_left = 0;
        pm_deadline = '0; pm_pos = 0; pm_worst_cnt = '0;
        for (int k = 0; k < TableEntries; k++) pm_valid[k] = 1'b0;
        for (int k = 0; k < Window; k++) pm_ring[k] = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_deadline(32'd0);

        // Directed rows; only reads of an empty table have results typed in.
        rows.push_back('{rd(6'd0), 1'b1, '0});
        rows.push_back('{rd(6'd63), 1'b1, '0});
        rows.push_back('{rec(8'h00, 8'h00, 0, 0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{rec(8'hFF, 8'hFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0});
        rows.push_back('{rec(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0), 1'b0, '0});
        rows.push_back('{rec(8'h00, 8'h00, 5, 10, 32'hFFFF_FFFF, 7, 9), 1'b0, '0});
        rows.push_back('{rec(8'h00, 8'h00, 5, 10, 1, 3, 2), 1'b0, '0});
        rows.push_back('{rec(8'hA5, 8'h5A, 1, 1, 1, 1, 1), 1'b0, '0});
        rows.push_back('{rec(8'h5A, 8'hA5, 0, 1, 1, 1, 1), 1'b0, '0});
        rows.push_back('{rec(8'h5A, 8'hA5, 0, 2, 2, 2, 2), 1'b0, '0});
        rows.push_back('{rec(8'h5A, 8'hA5, 0, 3, 3, 3, 3), 1'b0, '0});
        rows.push_back('{rd(6'd0), 1'b0, '0});
        rows.push_back('{rd(6'd1), 1'b0, '0});
        rows.push_back('{rd(6'd3), 1'b0, '0});
        rows.push_back('{rd(6'd4), 1'b0, '0});
        rows.push_back('{rd(6'd62), 1'b0, '0});
        foreach (rows[r]) begin
            if (rows[r].known) begin
                // Results typed in for the table right after reset.
                e = rows[r].result;
                send_item(rows[r].stim);
                void'(expected_beats.pop_back());
                expected_beats.push_back(e);
            end else begin
                send_item(rows[r].stim);
            end
        end

        set_deadline(32'hFFFF_FFFF);
        for (int n = 0; n < 100; n++) send_item(random_item());
        set_deadline(32'd50);
        for (int n = 0; n < 350; n++) send_item(random_item());
        set_deadline($urandom);
        for (int n = 0; n < 150; n++) send_item(random_item());
        set_deadline(32'd20);
        for (int n = 0; n < NumRandom - 600; n++) send_item(random_item());
        i_valid <= 1'b0;

        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        $display("Run covered %0d beats in (%0d reads), %0d results, %0d misses, %0d drops.",
                 n_in, n_read, n_out, n_miss, n_drop);
        if (n_err == 0 && expected_beats.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
